// File: src/overwriting_log_ring_assert.svh
// Assertion macros used by the ring core.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef OVERWRITING_LOG_RING_ASSERT_SVH
`define OVERWRITING_LOG_RING_ASSERT_SVH

`ifndef SYNTHESIS

// expr holds at every clock edge out of reset
`define OLR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("olr: invariant violated");

// cons holds on the edge after ante
`define OLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("olr: next-cycle check failed");

`else

`define OLR_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define OLR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/olr_pkg.sv
package olr_pkg;

	localparam int RING_DEPTH = 8192;
	localparam int ADDR_W     = $clog2(RING_DEPTH);
	localparam int PTR_W      = $clog2(2 * RING_DEPTH);
	localparam int BYTE_W     = 8;
	localparam int PEND_W     = 14;
	localparam int LOST_W     = 32;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam ptr_t DEPTH_P  = PTR_W'(RING_DEPTH);
	localparam ptr_t PTR_LAST = PTR_W'(2 * RING_DEPTH - 1);
	localparam ptr_t PTR_SPAN = PTR_W'(2 * RING_DEPTH);

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_READ  = 1'b1
	} kind_t;

	// one result, read_valid in the lowest bit
	typedef struct packed {
		logic              wake_readers;
		logic              readable;
		logic [LOST_W-1:0] lost_count;
		logic [PEND_W-1:0] pending_count;
		logic [BYTE_W-1:0] read_byte;
		logic              read_valid;
	} olr_result_t;

	localparam int RES_W       = $bits(olr_result_t);
	localparam int TDATA_OUT_W = ((RES_W + 7) / 8) * 8;

	// pointers run modulo twice the depth
	function automatic ptr_t ptr_adv(ptr_t p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic addr_t ptr_slot(ptr_t p);
		ptr_t s;
		s = (p >= DEPTH_P) ? p - DEPTH_P : p;
		return s[ADDR_W-1:0];
	endfunction

	function automatic ptr_t ptr_diff(ptr_t w, ptr_t r);
		ptr_t d;
		d = w - r;
		if (w < r) begin
			d = d + PTR_SPAN;
		end
		return d;
	endfunction

endpackage

// File: src/olr_core.sv
`include "overwriting_log_ring_assert.svh"

module olr_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  olr_pkg::kind_t        in_kind,
	input  logic [7:0]            in_byte,
	input  logic                  in_eob,
	output logic                  out_valid,
	input  logic                  out_ready,
	output olr_pkg::olr_result_t  out_res
);
	import olr_pkg::*;

	logic [BYTE_W-1:0] mem [RING_DEPTH];

	ptr_t              wr_ptr_q, rd_ptr_q, held;
	logic [LOST_W-1:0] lost_q;
	addr_t             addr;
	logic              accept, is_wr, full, nonempty;

	logic              vld_s1, rvalid_s1, wake_s1;
	logic [BYTE_W-1:0] rdata_s1;

	assign held     = ptr_diff(wr_ptr_q, rd_ptr_q);
	assign full     = (held == DEPTH_P);
	assign nonempty = (held != '0);
	assign in_ready = !vld_s1 || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_wr    = (in_kind == KIND_WRITE);
	assign addr     = ptr_slot(is_wr ? wr_ptr_q : rd_ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			lost_q   <= '0;
		end else if (accept) begin
			if (is_wr) begin
				wr_ptr_q <= ptr_adv(wr_ptr_q);
				if (full) begin
					rd_ptr_q <= ptr_adv(rd_ptr_q);
					lost_q   <= lost_q + 1'b1;
				end
			end else if (nonempty) begin
				rd_ptr_q <= ptr_adv(rd_ptr_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_wr) begin
			mem[addr] <= in_byte;
		end
		if (accept && !is_wr) begin
			rdata_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (out_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	// a write always leaves data pending, so eob alone raises wake
	always_ff @(posedge clk) begin
		if (accept) begin
			rvalid_s1 <= !is_wr && nonempty;
			wake_s1   <= is_wr && in_eob;
		end
	end

	// pointers and lost count only move on accept, so they match the held result
	always_comb begin
		out_res.read_valid    = rvalid_s1;
		out_res.read_byte     = rvalid_s1 ? rdata_s1 : '0;
		out_res.pending_count = PEND_W'(held);
		out_res.lost_count    = lost_q;
		out_res.readable      = nonempty;
		out_res.wake_readers  = wake_s1;
	end
	assign out_valid = vld_s1;

	`OLR_ASSERT_ALWAYS(a_held_range, clk, arst_n, held <= DEPTH_P)
	`OLR_ASSERT_NEXT(a_full_write_loses, clk, arst_n, accept && is_wr && full, lost_q == $past(lost_q) + 1'b1)
	`OLR_ASSERT_NEXT(a_read_moves_tail, clk, arst_n, accept && !is_wr && nonempty, rd_ptr_q != $past(rd_ptr_q))

endmodule

// File: src/olr_skid.sv
module olr_skid (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  olr_pkg::olr_result_t  in_res,
	output logic                  out_valid,
	input  logic                  out_ready,
	output olr_pkg::olr_result_t  out_res
);
	import olr_pkg::*;

	olr_result_t main_q, skid_q;
	logic        main_vld_q, skid_vld_q, in_fire;

	assign in_ready  = !skid_vld_q;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = main_vld_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!main_vld_q || out_ready) begin
			if (skid_vld_q) begin
				main_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_vld_q || out_ready) begin
			if (skid_vld_q) begin
				main_q <= skid_q;
			end else if (in_fire) begin
				main_q <= in_res;
			end
		end else if (in_fire) begin
			skid_q <= in_res;
		end
	end

endmodule

// File: src/overwriting_log_ring.sv
// overwriting_log_ring: byte log ring that overwrites its oldest data.
// A result passes the core's result register and then the skid's main register before it shows on m_tvalid.
// Throughput: one transaction per cycle while m_tready keeps up; the single-port byte memory sees one access per item.
// A full output skid stage stalls input only after three results are left waiting.
// Reset (arst_n low, async): pointers, lost count and valid flags clear; memory is not cleared.
module overwriting_log_ring (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream: one write or read request per transaction
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // [7:0] data_byte
	input  logic                            s_tuser,  // kind: 0 write, 1 read
	input  logic                            s_tlast,  // end_of_burst
	// result stream: one result per input transaction
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] read_valid, [8:1] read_byte, [22:9] pending_count,
	// [54:23] lost_count, [55] readable, [56] wake_readers, [63:57] zero
	output logic [olr_pkg::TDATA_OUT_W-1:0] m_tdata
);
	import olr_pkg::*;

	olr_result_t core_res, out_res;
	logic        core_vld, skid_rdy;

	// Core: pointer update, memory access and result stage in one pass.
	// A write into a full ring drags the tail along and bumps the lost count.
	olr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (kind_t'(s_tuser)),
		.in_byte   (s_tdata),
		.in_eob    (s_tlast),
		.out_valid (core_vld),
		.out_ready (skid_rdy),
		.out_res   (core_res)
	);

	// Skid: keeps m_tready off the input-side ready path.
	olr_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (core_vld),
		.in_ready  (skid_rdy),
		.in_res    (core_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// zero pad up to whole bytes
	assign m_tdata = TDATA_OUT_W'(out_res);

endmodule

// File: tb/sv/overwriting_log_ring_tb.sv
module overwriting_log_ring_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import olr_pkg::*;

	localparam int SPAN        = 2 * RING_DEPTH;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 16;
	localparam int IDLE_PCT    = 32;

	// one request; hold makes the sender wait until every result is back
	typedef struct {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic              eob;
		bit                hold;
	} ring_req_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;  // [7:0] data_byte
	logic                   s_tuser;  // kind
	logic                   s_tlast;  // end_of_burst
	logic                   m_tvalid;
	logic                   m_tready;
	logic [TDATA_OUT_W-1:0] m_tdata;  // read_valid, read_byte, pending, lost, readable, wake

	overwriting_log_ring DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow ring
	logic [BYTE_W-1:0] shadow_mem [RING_DEPTH];
	int                head_ptr;
	int                tail_ptr;
	logic [LOST_W-1:0] lost_total;

	ring_req_t   req_q [$];
	olr_result_t result_q [$];
	ring_req_t   cur_req;
	bit          in_taken;
	int          stall_cycles;
	int          n_in, n_out, n_errors;
	int          n_writes, n_reads, n_empty_reads, n_overwrites, n_wakes, peak_fill;

	// no idling on either side for a long stretch in the middle of the run
	wire quiet = (n_in >= 150) && (n_in < 300);

	function automatic int ring_held();
		return (head_ptr - tail_ptr + SPAN) % SPAN;
	endfunction

	function automatic olr_result_t ring_apply(ring_req_t req);
		olr_result_t r;
		int          held;
		r = '0;
		if (req.kind == KIND_WRITE) begin
			n_writes++;
			shadow_mem[head_ptr % RING_DEPTH] = req.data;
			head_ptr = (head_ptr + 1) % SPAN;
			// full ring: oldest byte is dropped
			if (ring_held() > RING_DEPTH) begin
				tail_ptr = (tail_ptr + 1) % SPAN;
				lost_total = lost_total + 1'b1;
				n_overwrites++;
			end
			r.wake_readers = req.eob && (ring_held() != 0);
		end else begin
			n_reads++;
			if (head_ptr != tail_ptr) begin
				r.read_byte  = shadow_mem[tail_ptr % RING_DEPTH];
				r.read_valid = 1'b1;
				tail_ptr     = (tail_ptr + 1) % SPAN;
			end else begin
				n_empty_reads++;
			end
		end
		held            = ring_held();
		r.pending_count = PEND_W'(held);
		r.lost_count    = lost_total;
		r.readable      = (held != 0);
		if (r.wake_readers) n_wakes++;
		if (held > peak_fill) peak_fill = held;
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			n_errors++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endfunction

	task automatic add_req(kind_t k, logic [7:0] d, logic e, bit h);
		ring_req_t r;
		r.kind = k;
		r.data = d;
		r.eob  = e;
		r.hold = h;
		req_q.push_back(r);
	endtask

	// bursts of one kind with random content; a few bursts miss or misplace eob
	task automatic add_bursts(int count, int write_pct);
		int    left;
		int    len;
		kind_t k;
		left = count;
		while (left > 0) begin
			len = $urandom_range(12, 1);
			if (len > left) len = left;
			k = ($urandom_range(99) < write_pct) ? KIND_WRITE : KIND_READ;
			for (int i = 0; i < len; i++) begin
				add_req(k, 8'($urandom),
					(i == len - 1) ? ($urandom_range(99) < 85) : ($urandom_range(19) == 0), 1'b0);
			end
			left -= len;
		end
	endtask

	// acceptance, prediction, result checking and the watchdog
	always @(posedge clk) begin : accept_blk
		olr_result_t want;
		olr_result_t got;
		if (arst_n) begin
			in_taken = s_tvalid && s_tready;
			if (in_taken) begin
				result_q.push_back(ring_apply(cur_req));
				n_in++;
			end
			if (m_tvalid && m_tready) begin
				n_out++;
				if (result_q.size() == 0) begin
					n_errors++;
					$display("%0t: result expected none got %0h", $time, m_tdata);
				end else begin
					want = result_q.pop_front();
					got  = olr_result_t'(m_tdata[RES_W-1:0]);
					check_field("read_valid", want.read_valid, got.read_valid);
					check_field("read_byte", want.read_byte, got.read_byte);
					check_field("pending_count", want.pending_count, got.pending_count);
					check_field("lost_count", want.lost_count, got.lost_count);
					check_field("readable", want.readable, got.readable);
					check_field("wake_readers", want.wake_readers, got.wake_readers);
					check_field("tdata padding", '0, m_tdata[TDATA_OUT_W-1:RES_W]);
				end
			end
			if (in_taken || (m_tvalid && m_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("%0t: no transaction for %0d cycles, %0d results outstanding",
						$time, STALL_LIMIT, result_q.size());
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
	end

	// sender and receiver change their signals on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (req_q.size() != 0 && !(req_q[0].hold && result_q.size() != 0) &&
				    (quiet || $urandom_range(99) >= IDLE_PCT)) begin
					cur_req = req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= cur_req.data;
					s_tuser  <= cur_req.kind;
					s_tlast  <= cur_req.eob;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = KIND_WRITE;
		s_tlast    = 1'b0;
		m_tready   = 1'b0;
		head_ptr   = 0;
		tail_ptr   = 0;
		lost_total = '0;
		in_taken   = 1'b0;

		// directed: empty reads, byte extremes, eob on reads and writes
		add_req(KIND_READ,  8'h00, 1'b0, 1'b0);
		add_req(KIND_READ,  8'hFF, 1'b1, 1'b0);
		add_req(KIND_WRITE, 8'h00, 1'b0, 1'b0);
		add_req(KIND_WRITE, 8'hFF, 1'b1, 1'b0);
		add_req(KIND_WRITE, 8'hA5, 1'b0, 1'b0);
		add_req(KIND_READ,  8'h00, 1'b1, 1'b0);
		add_req(KIND_READ,  8'h00, 1'b0, 1'b0);
		add_req(KIND_READ,  8'hFF, 1'b1, 1'b0);
		add_req(KIND_READ,  8'h00, 1'b0, 1'b0);
		add_req(KIND_WRITE, 8'h5A, 1'b1, 1'b0);
		add_req(KIND_READ,  8'h00, 1'b0, 1'b0);
		add_req(KIND_WRITE, 8'h01, 1'b0, 1'b0);
		add_req(KIND_WRITE, 8'h80, 1'b1, 1'b0);
		add_req(KIND_READ,  8'h00, 1'b0, 1'b0);
		add_req(KIND_READ,  8'h00, 1'b1, 1'b0);
		add_req(KIND_READ,  8'h00, 1'b0, 1'b0);

		// build up a backlog of written bytes
		for (int i = 0; i < 100; i++) begin
			add_req(KIND_WRITE, 8'($urandom), $urandom_range(15) == 0, i == 0);
		end
		// write-heavy mixed traffic, then drain past empty
		add_bursts(120, 65);
		for (int i = 0; i < 160; i++) begin
			add_req(KIND_READ, 8'($urandom), 1'($urandom), i == 0);
		end
		// balanced traffic around empty
		add_req(KIND_WRITE, 8'h3C, 1'b1, 1'b1);
		add_bursts(100, 50);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (req_q.size() != 0 || s_tvalid || result_q.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("ran %0d requests: %0d writes, %0d reads (%0d on an empty ring), %0d results",
			n_in, n_writes, n_reads, n_empty_reads, n_out);
		$display("peak fill %0d bytes, %0d overwrites, %0d wake flags, %0d errors",
			peak_fill, n_overwrites, n_wakes, n_errors);
		if (n_errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
